// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DZQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DZQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DZQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define DZQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/dzq_pkg.sv
// ----------------------------------------------------------------------------
// dzq_pkg
// Widths, register indexes and pipeline types of the dead-zone quantizer.
// ----------------------------------------------------------------------------
package dzq_pkg;

  localparam int COEF_W    = 13;  // signed coefficient
  localparam int CFG_W     = 12;  // step size and dead zone
  localparam int CFG_IDX_W = 2;
  localparam int LEVEL_W   = 8;
  localparam int RECON_W   = 14;
  localparam int REM_W     = 13;  // magnitude minus dead zone, never negative
  localparam int QUO_W     = 8;   // quotient bits produced by the divider
  localparam int DIV_W     = REM_W + QUO_W - 1;
  localparam int SUM_W     = 21;  // dz + (level-1)*q + q/2
  localparam int PROD_W    = LEVEL_W + CFG_W;

  localparam logic [LEVEL_W-1:0]   LEVEL_MAX     = 8'd255;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd1;

  typedef struct packed {
    logic valid;
    logic neg;
    logic indz;   // magnitude below the dead zone
  } ctl_t;

  typedef struct packed {
    ctl_t               ctl;
    logic               ovf;  // quotient does not fit in QUO_W bits
    logic [REM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
  } div_t;

endpackage

// File: hdl/dzq_if.sv
// ----------------------------------------------------------------------------
// dzq channel interfaces
// Valid/ready channels for coefficients, results and register writes.
// ----------------------------------------------------------------------------
interface dzq_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dzq_pkg::COEF_W-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

interface dzq_out_if;
  logic                               valid;
  logic                               ready;
  logic        [dzq_pkg::LEVEL_W-1:0] level_index;
  logic                               negative;
  logic signed [dzq_pkg::RECON_W-1:0] recon_value;

  modport source (output valid, output level_index, output negative,
                  output recon_value, input ready);
  modport sink   (input valid, input level_index, input negative,
                  input recon_value, output ready);
endinterface

interface dzq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dzq_pkg::CFG_IDX_W-1:0]     index;
  logic [dzq_pkg::CFG_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/deadzone_scalar_quantizer.sv
// ----------------------------------------------------------------------------
// deadzone_scalar_quantizer
// Dead-zone uniform scalar quantizer with mid-bin reconstruction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed 13-bit coefficient per transaction.
//   out_ch : level_index, negative flag and signed recon_value, one result
//            transaction for every input transaction, in order.
//   cfg_ch : register writes, index 0 step_size, index 1 dead_zone; always
//            ready. Other indexes are ignored. Write only while idle.
// Timing:
//   Throughput is one coefficient per cycle while out_ch is not stalled: the
//   pipeline is one input stage, four divider stages (two quotient bits
//   each), a multiply stage, a sum stage and the output register.
// Reset:
//   rst_n (synchronous) empties the pipeline and sets step_size and
//   dead_zone to 1.
// Stall:
//   while out_ch holds a result that is not taken, the whole pipeline
//   freezes and in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deadzone_scalar_quantizer #(
  parameter int MAX_MAGNITUDE = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  dzq_in_if.sink     in_ch,
  dzq_out_if.source  out_ch,
  dzq_cfg_if.sink    cfg_ch
);

  localparam int MAG_W = $clog2(MAX_MAGNITUDE + 1);

  // configuration
  logic [dzq_pkg::CFG_W-1:0] step_r, dz_r;
  logic [dzq_pkg::CFG_W-1:0] q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dzq_pkg::CFG_W'(1);
      dz_r   <= dzq_pkg::CFG_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        dzq_pkg::REG_STEP_SIZE: step_r <= cfg_ch.data;
        dzq_pkg::REG_DEAD_ZONE: dz_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // zero step behaves as one
  assign q = (step_r == '0) ? dzq_pkg::CFG_W'(1) : step_r;

  // global advance: move unless the output register holds a stalled result
  logic en;
  logic out_valid_r;
  assign en          = out_ch.ready || !out_valid_r;
  assign in_ch.ready = en;

  // stage 1: magnitude, offset into the bins, overflow check
  logic [dzq_pkg::COEF_W-1:0]  raw, mag;
  logic                        neg;
  logic [dzq_pkg::REM_W:0]     diff;
  logic [dzq_pkg::SUM_W-1:0]   ovf_lim;
  dzq_pkg::div_t               s1_nxt, s1_r;

  always_comb begin
    raw     = in_ch.coefficient;
    neg     = raw[dzq_pkg::COEF_W-1];
    mag     = neg ? (~raw + dzq_pkg::COEF_W'(1)) : raw;
    diff    = {1'b0, mag} - (dzq_pkg::REM_W + 1)'(dz_r);
    ovf_lim = dzq_pkg::SUM_W'(dz_r) + (dzq_pkg::SUM_W'(q) << dzq_pkg::QUO_W);
    s1_nxt.ctl.valid = in_ch.valid;
    s1_nxt.ctl.neg   = neg;
    s1_nxt.ctl.indz  = diff[dzq_pkg::REM_W];
    s1_nxt.ovf       = dzq_pkg::SUM_W'(mag) >= ovf_lim;
    s1_nxt.rem       = diff[dzq_pkg::REM_W-1:0];
    s1_nxt.quo       = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.ctl.valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // stages 2..5: quotient bits 7..0
  dzq_pkg::div_t d1, d2, d3, d4;

  dzq_div_stage #(.BIT_HI(7)) u_div0 (
    .clk(clk), .rst_n(rst_n), .en(en), .q(q), .st_in(s1_r), .st_out(d1)
  );
  dzq_div_stage #(.BIT_HI(5)) u_div1 (
    .clk(clk), .rst_n(rst_n), .en(en), .q(q), .st_in(d1), .st_out(d2)
  );
  dzq_div_stage #(.BIT_HI(3)) u_div2 (
    .clk(clk), .rst_n(rst_n), .en(en), .q(q), .st_in(d2), .st_out(d3)
  );
  dzq_div_stage #(.BIT_HI(1)) u_div3 (
    .clk(clk), .rst_n(rst_n), .en(en), .q(q), .st_in(d3), .st_out(d4)
  );

  // stage 6: saturated level and (level - 1) * q
  logic [dzq_pkg::LEVEL_W-1:0] lvl_nxt, lvl_m1;
  logic [dzq_pkg::LEVEL_W-1:0] s6_lvl_r;
  logic [dzq_pkg::PROD_W-1:0]  s6_prod_r;
  dzq_pkg::ctl_t               s6_ctl_r;

  always_comb begin
    if (d4.ovf || d4.quo == dzq_pkg::LEVEL_MAX) begin
      lvl_m1  = dzq_pkg::LEVEL_MAX - dzq_pkg::LEVEL_W'(1);
      lvl_nxt = dzq_pkg::LEVEL_MAX;
    end else begin
      lvl_m1  = d4.quo;
      lvl_nxt = d4.quo + dzq_pkg::LEVEL_W'(1);
    end
    if (d4.ctl.indz) begin
      lvl_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_ctl_r.valid <= 1'b0;
    end else if (en) begin
      s6_ctl_r  <= d4.ctl;
      s6_lvl_r  <= lvl_nxt;
      s6_prod_r <= dzq_pkg::PROD_W'(lvl_m1) * dzq_pkg::PROD_W'(q);
    end
  end

  // stage 7: mid-bin value = low + floor(q / 2)
  logic [dzq_pkg::SUM_W-1:0]   s7_sum_r;
  logic [dzq_pkg::LEVEL_W-1:0] s7_lvl_r;
  dzq_pkg::ctl_t               s7_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_ctl_r.valid <= 1'b0;
    end else if (en) begin
      s7_ctl_r <= s6_ctl_r;
      s7_lvl_r <= s6_lvl_r;
      s7_sum_r <= dzq_pkg::SUM_W'(dz_r) + dzq_pkg::SUM_W'(s6_prod_r)
                + dzq_pkg::SUM_W'(q >> 1);
    end
  end

  // stage 8: clamp, sign, output register
  logic [MAG_W-1:0]                  clamped;
  logic [dzq_pkg::RECON_W-1:0]       recon_mag, recon_nxt;
  logic [dzq_pkg::LEVEL_W-1:0]       out_level_r;
  logic                              out_neg_r;
  logic [dzq_pkg::RECON_W-1:0]       out_recon_r;

  always_comb begin
    if (s7_sum_r > dzq_pkg::SUM_W'(MAX_MAGNITUDE)) begin
      clamped = MAG_W'(MAX_MAGNITUDE);
    end else begin
      clamped = s7_sum_r[MAG_W-1:0];
    end
    recon_mag = s7_ctl_r.indz ? '0 : dzq_pkg::RECON_W'(clamped);
    recon_nxt = s7_ctl_r.neg ? (~recon_mag + dzq_pkg::RECON_W'(1)) : recon_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s7_ctl_r.valid;
      out_level_r <= s7_lvl_r;
      out_neg_r   <= s7_ctl_r.neg && !s7_ctl_r.indz;
      out_recon_r <= recon_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.level_index = out_level_r;
  assign out_ch.negative    = out_neg_r;
  assign out_ch.recon_value = out_recon_r;

  // checks
  `DZQ_ASSERT_IMPL(a_div_rem_lt_step,
    d4.ctl.valid && !d4.ctl.indz && !d4.ovf,
    d4.rem < dzq_pkg::REM_W'(q), "divider remainder not below step")
  `DZQ_ASSERT_IMPL(a_zero_level_zero_result,
    out_ch.valid && out_ch.level_index == '0,
    out_ch.recon_value == '0 && !out_ch.negative, "level 0 with nonzero result")
  `DZQ_ASSERT_NEXT(a_stall_freezes_stage,
    s7_ctl_r.valid && out_ch.valid && !out_ch.ready,
    s7_ctl_r.valid, "pipeline stage dropped during stall")

endmodule

// File: hdl/dzq_div_stage.sv
// ----------------------------------------------------------------------------
// dzq_div_stage
// Two restoring division steps (quotient bits BIT_HI and BIT_HI-1), registered.
// ----------------------------------------------------------------------------
module dzq_div_stage #(
  parameter int BIT_HI = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [dzq_pkg::CFG_W-1:0]  q,
  input  dzq_pkg::div_t              st_in,
  output dzq_pkg::div_t              st_out
);

  localparam int B0 = BIT_HI;
  localparam int B1 = BIT_HI - 1;

  logic [dzq_pkg::DIV_W-1:0] t0, t1;
  logic [dzq_pkg::REM_W-1:0] rem_mid;
  dzq_pkg::div_t             st_nxt, st_r;

  always_comb begin
    st_nxt  = st_in;
    t0      = dzq_pkg::DIV_W'(q) << B0;
    t1      = dzq_pkg::DIV_W'(q) << B1;
    rem_mid = st_in.rem;
    if (dzq_pkg::DIV_W'(st_in.rem) >= t0) begin
      rem_mid        = st_in.rem - t0[dzq_pkg::REM_W-1:0];
      st_nxt.quo[B0] = 1'b1;
    end
    st_nxt.rem = rem_mid;
    if (dzq_pkg::DIV_W'(rem_mid) >= t1) begin
      st_nxt.rem     = rem_mid - t1[dzq_pkg::REM_W-1:0];
      st_nxt.quo[B1] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.ctl.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule
